// ===== rtl/core/mtwg_pkg.sv =====
// Package with the constants, control types and twist math of the MT19937 word generator.
`default_nettype none
package mtwg_pkg;

   localparam int unsigned STATE_WORDS = 624;
   localparam int unsigned TAP_OFFSET  = 397;
   localparam int unsigned CNT_W       = 10;

   localparam logic [31:0] MATRIX_WORD = 32'h9908_b0df;
   localparam logic [31:0] TEMPER_B    = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C    = 32'hefc6_0000;
   localparam logic [16:0] SEED_MULT   = 17'd69069;
   localparam logic [31:0] SEED_RESET  = 32'd4357;
   localparam logic [31:0] HIGH_BIT    = 32'h8000_0000;
   localparam logic [31:0] LOW_BITS    = 32'h7fff_ffff;

   localparam logic [CNT_W-1:0] SEED_LAST = CNT_W'(STATE_WORDS - 1);

   localparam logic [2:0] CSR_SEED_ADDR = 3'd0;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_SEED,
      ST_EMIT
   } fsm_type;

   // Controls handed from the sequencer to the feed unit and the cell row.
   typedef struct packed {
      logic shift;      // the row moves one place toward the head
      logic use_seed;   // the tail takes the seeding sequence, not the twist
      logic load_seed;  // start a new seeding sequence from the seed register
   } ctl_type;

   // One step of the twist recurrence: x[n+624] from x[n], x[n+1] and x[n+397].
   function automatic logic [31:0] twist_word(input logic [31:0] head,
                                               input logic [31:0] next,
                                               input logic [31:0] tap);
      logic [31:0] y;
      logic [31:0] v;
      begin
         y = (head & HIGH_BIT) | (next & LOW_BITS);
         v = tap ^ (y >> 1);
         if (y[0]) begin
            v = v ^ MATRIX_WORD;
         end
         return v;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mtwg_cell.sv =====
// One cell of the state row: a 32-bit word that moves to its neighbor on each shift.
`default_nettype none
module mtwg_cell (
   input  wire logic        clock,
   input  wire logic        shift,
   input  wire logic [31:0] word_in,
   output logic      [31:0] word_out
);
   logic [31:0] word_ff;
   logic [31:0] word_in_sel;

   // Holds its word unless the row shifts.
   assign word_in_sel = shift ? word_in : word_ff;

   always_ff @(posedge clock) begin
      word_ff <= word_in_sel;
   end

   assign word_out = word_ff;

endmodule
`default_nettype wire

// ===== rtl/core/mtwg_feed.sv =====
// Feed unit: produces the word entering the tail of the row, from seeding or twisting.
`default_nettype none
module mtwg_feed (
   input  wire logic                 clock,
   input  wire mtwg_pkg::ctl_type    ctl,
   input  wire logic [31:0]          seed_value,
   input  wire logic [31:0]          head_word,
   input  wire logic [31:0]          next_word,
   input  wire logic [31:0]          tap_word,
   output logic      [31:0]          tail_word
);
   import mtwg_pkg::*;

   logic [31:0] seed_run_ff;
   logic [31:0] seed_run_in;
   logic [48:0] seed_prod;

   // Running term of the seeding sequence, multiplied once per shifted word.
   assign seed_prod = seed_run_ff * SEED_MULT;

   always_comb begin
      seed_run_in = seed_run_ff;
      if (ctl.load_seed) begin
         seed_run_in = seed_value;
      end else if (ctl.shift && ctl.use_seed) begin
         seed_run_in = seed_prod[31:0];
      end
   end

   always_ff @(posedge clock) begin
      seed_run_ff <= seed_run_in;
   end

   assign tail_word = ctl.use_seed ? seed_run_ff
                                   : twist_word(head_word, next_word, tap_word);

endmodule
`default_nettype wire

// ===== rtl/core/mersenne_twister_word_generator.sv =====
// An accepted request's word is twisted, tempered and registered in the output register; one word
// per cycle is sustained while no seeding is needed and the result side does not stall. A request
// that seeds (reseed set, or the first after reset) loads the seed, shifts the seeding sequence
// through the row, one multiply a cycle, and then twists and registers the word.
// The 624-cell row shifts one place per word, so the twist keeps pace with the output.
// Reset (synchronous) clears the handshake, the sequencer and the seeded flag and
// sets the seed register to 4357; the state row holds no value until it is seeded.
`default_nettype none
module mersenne_twister_word_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_reseed,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [31:0] rsp_random_word,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import mtwg_pkg::*;

   // ------------------------------------------------------------------
   // Configuration register. The seed is the only register; a write to any
   // other address is dropped, and a read of one returns zero.
   // ------------------------------------------------------------------
   logic [31:0] seed_ff;
   logic [31:0] seed_in;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      seed_in = seed_ff;
      if (csr_write && (csr_paddr == CSR_SEED_ADDR)) begin
         seed_in = csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_SEED_ADDR) begin
         csr_prdata = seed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer. In RUN a request that needs no seeding is served at once:
   // the row shifts, the twisted word enters the tail and its tempered form
   // goes to the output register. A request that needs seeding moves to SEED,
   // where the seeding sequence x[i] = 69069 * x[i-1] is shifted in, one word
   // a cycle, until the head holds the seed. EMIT then serves the request
   // with the first twisted word. The output register is empty on the way
   // out of RUN, so EMIT never has to wait for the result side.
   // ------------------------------------------------------------------
   fsm_type          fsm_ff;
   fsm_type          fsm_in;
   logic [CNT_W-1:0] seed_cnt_ff;
   logic [CNT_W-1:0] seed_cnt_in;
   logic             seeded_ff;
   logic             seeded_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [31:0]      rsp_word_ff;
   logic [31:0]      rsp_word_in;
   logic             out_free;
   logic             req_accept;
   logic             need_seed;
   logic             step;
   ctl_type          ctl;

   // The output register can take a word when it is empty or its beat leaves now.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign need_seed  = req_reseed || !seeded_ff;

   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         ST_RUN: begin
            if (req_accept && need_seed) begin
               fsm_in = ST_SEED;
            end
         end
         ST_SEED: begin
            if (seed_cnt_ff == SEED_LAST) begin
               fsm_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            fsm_in = ST_RUN;
         end
         default: begin
            fsm_in = ST_RUN;
         end
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      step          = 1'b0;
      ctl.shift     = 1'b0;
      ctl.use_seed  = 1'b0;
      ctl.load_seed = 1'b0;
      unique case (fsm_ff)
         ST_RUN: begin
            req_stall = !out_free;
            if (req_accept) begin
               if (need_seed) begin
                  ctl.load_seed = 1'b1;
               end else begin
                  step      = 1'b1;
                  ctl.shift = 1'b1;
               end
            end
         end
         ST_SEED: begin
            ctl.shift    = 1'b1;
            ctl.use_seed = 1'b1;
         end
         ST_EMIT: begin
            step      = 1'b1;
            ctl.shift = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      seed_cnt_in = '0;
      if (fsm_ff == ST_SEED) begin
         seed_cnt_in = seed_cnt_ff + 1'b1;
      end
   end

   // The state counts as seeded once a seeding pass has finished.
   assign seeded_in = seeded_ff || (fsm_ff == ST_EMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff      <= ST_RUN;
         seed_cnt_ff <= '0;
         seeded_ff   <= 1'b0;
      end else begin
         fsm_ff      <= fsm_in;
         seed_cnt_ff <= seed_cnt_in;
         seeded_ff   <= seeded_in;
      end
   end

   // ------------------------------------------------------------------
   // State row. Cell 0 holds x[n], the word that the next twist replaces;
   // cell 623 holds the newest word. Each shift moves every word one cell
   // toward the head and puts the new word in the last cell, which is the
   // in-place twist of the state vector carried out one word at a time.
   // ------------------------------------------------------------------
   logic [31:0] row_word [STATE_WORDS];
   logic [31:0] tail_word;

   for (genvar i = 0; i < STATE_WORDS; i++) begin : g_row
      if (i == STATE_WORDS - 1) begin : g_tail
         mtwg_cell u_cell (
            .clock    (clock),
            .shift    (ctl.shift),
            .word_in  (tail_word),
            .word_out (row_word[i])
         );
      end else begin : g_body
         mtwg_cell u_cell (
            .clock    (clock),
            .shift    (ctl.shift),
            .word_in  (row_word[i+1]),
            .word_out (row_word[i])
         );
      end
   end

   mtwg_feed u_feed (
      .clock      (clock),
      .ctl        (ctl),
      .seed_value (seed_ff),
      .head_word  (row_word[0]),
      .next_word  (row_word[1]),
      .tap_word   (row_word[TAP_OFFSET]),
      .tail_word  (tail_word)
   );

   // ------------------------------------------------------------------
   // Tempering and the output register. The word that enters the tail on a
   // step is exactly the word the request asks for.
   // ------------------------------------------------------------------
   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      begin
         y = w;
         y = y ^ (y >> 11);
         y = y ^ ((y << 7) & TEMPER_B);
         y = y ^ ((y << 15) & TEMPER_C);
         y = y ^ (y >> 18);
         return y;
      end
   endfunction

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = temper(tail_word);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

endmodule
`default_nettype wire

// ===== sim/mersenne_twister_word_generator_test.sv =====
// Self-checking testbench for the MT19937 word generator: a directed table, then random traffic.
module mersenne_twister_word_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Generator arithmetic, kept locally so the predictor owns its own copy of the recurrence.
   localparam int unsigned MT_WORDS     = 624;
   localparam int unsigned MT_TAP       = 397;
   localparam int unsigned POS_UNSEEDED = MT_WORDS + 1;
   localparam logic [31:0] MT_MATRIX    = 32'h9908_b0df;
   localparam logic [31:0] MT_TEMPER_B  = 32'h9d2c_5680;
   localparam logic [31:0] MT_TEMPER_C  = 32'hefc6_0000;
   localparam logic [31:0] MT_SEED_MULT = 32'd69069;
   localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
   localparam logic [31:0] MT_LOWER     = 32'h7fff_ffff;

   // Register map: the seed register sits at byte address 0; the next word slot is unused.
   localparam logic [2:0] SEED_ADDR  = mtwg_pkg::CSR_SEED_ADDR;
   localparam logic [2:0] SPARE_ADDR = 3'd4;

   // Run shape. The limit covers roughly 1300 beats, each with a full sender gap and a full
   // receiver stall, a few dozen seeding passes and the long hold-off, several times over.
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned DRAIN_CYCLES  = 4;
   localparam int unsigned RANDOM_TARGET = 1150;
   localparam int unsigned QUIET_ITEMS   = 150;
   localparam int unsigned REPORT_LIMIT  = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_reseed;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_random_word;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mersenne_twister_word_generator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_reseed      (req_reseed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_random_word (rsp_random_word),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // ---------------------------------------------------------------------------------------
   // Word predictor. It mirrors the generator state: the 624-word vector, the read position
   // (625 means never seeded) and a shadow of the seed register.
   // ---------------------------------------------------------------------------------------
   logic [31:0] mt_state [0:MT_WORDS-1];
   int unsigned mt_pos;
   logic [31:0] seed_shadow;
   int unsigned seeding_count;
   int unsigned twist_count;

   function automatic void mt_seed(input logic [31:0] s);
      int unsigned i;
      mt_state[0] = s;
      for (i = 1; i < MT_WORDS; i++) begin
         mt_state[i] = mt_state[i-1] * MT_SEED_MULT;
      end
      mt_pos = MT_WORDS;
      seeding_count++;
   endfunction

   // Regenerates all 624 words in place; later words already see the updated early ones.
   function automatic void mt_twist();
      int unsigned k;
      logic [31:0] y;
      logic [31:0] v;
      for (k = 0; k < MT_WORDS; k++) begin
         y = (mt_state[k] & MT_UPPER) | (mt_state[(k + 1) % MT_WORDS] & MT_LOWER);
         v = mt_state[(k + MT_TAP) % MT_WORDS] ^ (y >> 1);
         if (y[0]) begin
            v = v ^ MT_MATRIX;
         end
         mt_state[k] = v;
      end
      mt_pos = 0;
      twist_count++;
   endfunction

   function automatic logic [31:0] mt_temper(input logic [31:0] w);
      logic [31:0] y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & MT_TEMPER_B);
      y = y ^ ((y << 15) & MT_TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // Advances the predictor by one request and returns the word the block must deliver.
   function automatic logic [31:0] mt_next_word(input logic reseed);
      logic [31:0] w;
      if (reseed || mt_pos >= POS_UNSEEDED) begin
         mt_seed(seed_shadow);
      end
      if (mt_pos >= MT_WORDS) begin
         mt_twist();
      end
      w = mt_state[mt_pos];
      mt_pos++;
      return mt_temper(w);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Expected words, oldest first, and the run's bookkeeping.
   // ---------------------------------------------------------------------------------------
   typedef struct {
      logic [31:0] word;
      bit          fixed;   // typed in by hand rather than computed
      int unsigned serial;
   } word_expect_type;

   word_expect_type pending_words [$];

   int unsigned requests_sent;
   int unsigned words_checked;
   int unsigned mismatch_count;
   int unsigned register_writes;
   int unsigned cycle_count;
   bit          hold_off_req;
   bit          quiet;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Directed table. Rows with cfg set first wait for the block to go idle, then write the
   // register at addr. A word is typed in only where it is obvious: a zero seed gives zero.
   // ---------------------------------------------------------------------------------------
   typedef struct packed {
      logic        cfg;
      logic [2:0]  addr;
      logic [31:0] data;
      logic        reseed;
      logic        known;
      logic [31:0] word;
   } step_row_type;

   localparam int unsigned DIRECTED_ROWS = 19;

   step_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      // The very first request after reset also asks for a reseed; it must seed only once.
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b1, 1'b0, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      // Reseeding with the same seed restarts the same sequence.
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b1, 1'b0, 32'h0},
      // A write to the unused register slot must leave the seed alone.
      '{1'b1, SPARE_ADDR, 32'hdead_beef, 1'b0, 1'b0, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b1, 1'b0, 32'h0},
      // A zero seed leaves every state word at zero, so every word out is zero.
      '{1'b1, SEED_ADDR,  32'h0000_0000, 1'b1, 1'b1, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b0, 1'b1, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b0, 1'b1, 32'h0},
      // Seed extremes.
      '{1'b1, SEED_ADDR,  32'hffff_ffff, 1'b1, 1'b0, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b1, SEED_ADDR,  32'h0000_0001, 1'b1, 1'b0, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b1, SEED_ADDR,  32'h8000_0000, 1'b1, 1'b0, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b1, SEED_ADDR,  32'h7fff_ffff, 1'b1, 1'b0, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      // A new seed without a reseed request must not disturb the running sequence.
      '{1'b1, SEED_ADDR,  32'd4357,      1'b0, 1'b0, 32'h0},
      '{1'b0, SEED_ADDR,  32'h0000_0000, 1'b1, 1'b0, 32'h0}
   };

   // ---------------------------------------------------------------------------------------
   // Request side. Everything is driven at the falling edge and the handshake is judged at
   // the rising edge, so no sample depends on event order within a step. A beat leaves
   // req_valid high; the next offer or an idle cycle decides its value at the next fall.
   // ---------------------------------------------------------------------------------------
   task automatic offer_request(input logic reseed, input bit fixed, input logic [31:0] word);
      word_expect_type e;
      logic [31:0]     predicted;
      @(negedge clock);
      req_valid  <= 1'b1;
      req_reseed <= reseed;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predicted = mt_next_word(reseed);
      e.word    = fixed ? word : predicted;
      e.fixed   = fixed;
      e.serial  = requests_sent;
      pending_words.push_back(e);
      requests_sent++;
   endtask

   task automatic idle_sender(input int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stops offering and waits until every expected word has come out and the block is idle.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access cycle until pready.
   task automatic csr_access(input bit write, input logic [2:0] addr, input logic [31:0] data,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (write && addr == SEED_ADDR) begin
         seed_shadow = data;
      end
   endtask

   task automatic check_seed_register();
      logic [31:0] value;
      csr_access(1'b0, SEED_ADDR, 32'h0, value);
      if (value !== seed_shadow) begin
         report_mismatch($sformatf("seed register reads %08h, expected %08h",
                                   value, seed_shadow));
      end
   endtask

   task automatic program_register(input logic [2:0] addr, input logic [31:0] data);
      logic [31:0] unused;
      csr_access(1'b1, addr, data, unused);
      register_writes++;
      check_seed_register();
   endtask

   // ---------------------------------------------------------------------------------------
   // Clock and cycle watchdog.
   // ---------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d words outstanding",
                  cycle_count, pending_words.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result side. The stall pattern runs in its own process: random free stretches and
   // stall bursts, one long hold-off on request, and none in the quiet tail.
   // ---------------------------------------------------------------------------------------
   initial begin
      int unsigned n;
      rsp_stall = 1'b0;
      while (reset) begin
         @(negedge clock);
      end
      forever begin
         if (hold_off_req) begin
            // Long hold-off while the sender keeps offering, so the block backs up.
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
            hold_off_req = 1'b0;
         end else if (quiet) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 25);
            repeat (n) begin
               @(negedge clock);
               rsp_stall <= 1'b0;
            end
            n = $urandom_range(1, 13);
            repeat (n) begin
               @(negedge clock);
               rsp_stall <= !quiet;
            end
         end
      end
   end

   // Every accepted word is compared with the oldest expectation.
   always @(posedge clock) begin
      word_expect_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("word %08h arrived with nothing expected",
                                      rsp_random_word));
         end else begin
            e = pending_words.pop_front();
            words_checked++;
            if (rsp_random_word !== e.word) begin
               report_mismatch($sformatf("request %0d%s: expected %08h, got %08h", e.serial,
                                         e.fixed ? " (fixed value)" : "", e.word,
                                         rsp_random_word));
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Main sequence: reset, directed table, random phases, quiet tail, verdict.
   // ---------------------------------------------------------------------------------------
   initial begin
      int unsigned  r;
      int unsigned  k;
      int unsigned  phase;
      int unsigned  phase_len;
      logic [31:0]  new_seed;
      bit           lead_reseed;
      bit           calm;
      step_row_type row;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_reseed    = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      hold_off_req  = 1'b0;
      quiet         = 1'b0;
      seed_shadow   = 32'd4357;
      mt_pos        = POS_UNSEEDED;
      requests_sent = 0;
      words_checked = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The seed register must come out of reset at its documented value.
      check_seed_register();

      for (r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_rows[r];
         if (row.cfg) begin
            drain_results();
            program_register(row.addr, row.data);
         end
         offer_request(row.reseed, row.known, row.word);
      end

      // Random phases. Reseeds are rare so that long runs cross the twist boundary several
      // times; each phase installs a new seed, sometimes an extreme one.
      phase = 0;
      while (requests_sent < RANDOM_TARGET) begin
         phase_len = $urandom_range(40, 200);
         drain_results();
         case ($urandom_range(0, 9))
            0:       new_seed = 32'h0000_0000;
            1:       new_seed = 32'hffff_ffff;
            2:       new_seed = 32'h8000_0000;
            3:       new_seed = 32'h7fff_ffff;
            default: new_seed = $urandom();
         endcase
         program_register(SEED_ADDR, new_seed);
         if ($urandom_range(0, 3) == 0) begin
            program_register(SPARE_ADDR, $urandom());
         end
         lead_reseed = ($urandom_range(0, 2) == 0);
         calm        = ($urandom_range(0, 3) == 0);
         if (phase == 2) begin
            hold_off_req = 1'b1;
         end
         for (k = 0; k < phase_len; k++) begin
            // Once in the run the sender stops mid-stream until every word is back.
            if (phase == 4 && k == phase_len / 2) begin
               drain_results();
            end
            if (!calm && $urandom_range(0, 7) == 0) begin
               idle_sender($urandom_range(1, 13));
            end
            offer_request((k == 0 && lead_reseed) || ($urandom_range(0, 299) == 0), 1'b0, '0);
         end
         phase++;
      end

      // Quiet tail: back-to-back beats with no stalls on either side.
      drain_results();
      quiet = 1'b1;
      for (k = 0; k < QUIET_ITEMS; k++) begin
         offer_request($urandom_range(0, 299) == 0, 1'b0, '0);
      end

      drain_results();

      $display("Ran %0d requests and checked %0d words in %0d cycles.",
               requests_sent, words_checked, cycle_count);
      $display("Covered %0d seedings, %0d twists of the state and %0d register writes.",
               seeding_count, twist_count, register_writes);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
